@@ hw/rtl/sli_pkg.sv @@
// Shared types and codes for the sorted span list intersect block.
package sli_pkg;

   localparam int SPAN_W = 64;

   // operation codes carried on req_tuser
   localparam logic [1:0] OP_LOAD_X = 2'd0;
   localparam logic [1:0] OP_LOAD_Y = 2'd1;
   localparam logic [1:0] OP_ISECT  = 2'd2;

   typedef struct packed {
      logic signed [SPAN_W-1:0] span_end;
      logic signed [SPAN_W-1:0] span_start;
   } span_type;

   // one result pushed from the walk sequencer into the output register
   typedef struct packed {
      logic                     valid;
      logic                     has_span;
      logic                     last;
      logic signed [SPAN_W-1:0] span_start_res;
      logic signed [SPAN_W-1:0] span_end_res;
   } emit_type;

endpackage

@@ hw/rtl/sli_cmp.sv @@
// Shared signed 64-bit less-than unit.
module sli_cmp (
   input  logic signed [63:0] a_in,
   input  logic signed [63:0] b_in,
   output logic               lt
);
   import sli_pkg::*;

   assign lt = (a_in < b_in);

endmodule

@@ hw/rtl/sli_span_mem.sv @@
// Span list storage: one write port, one registered read port.
module sli_span_mem #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  sli_pkg::span_type             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output sli_pkg::span_type             rd_data
);
   import sli_pkg::*;

   span_type mem_ff [DEPTH];
   span_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sli_walk.sv @@
// Two-pointer walk sequencer around one shared comparator.
module sli_walk #(
   parameter int SPAN_SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [$clog2(SPAN_SLOTS+1)-1:0]      x_count,
   input  logic [$clog2(SPAN_SLOTS+1)-1:0]      y_count,
   input  sli_pkg::span_type                    x_rd,
   input  sli_pkg::span_type                    y_rd,
   input  logic                                 out_free,
   output logic [$clog2(SPAN_SLOTS+1)-1:0]      x_ptr,
   output logic [$clog2(SPAN_SLOTS+1)-1:0]      y_ptr,
   output sli_pkg::emit_type                    emit,
   output logic                                 done,
   output logic                                 busy
);
   import sli_pkg::*;

   localparam int CNT_W = $clog2(SPAN_SLOTS+1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;  // memory read of the pair in flight
   localparam logic [2:0] S_LO   = 3'd2;  // lo = max of starts
   localparam logic [2:0] S_HI   = 3'd3;  // hi = min of ends
   localparam logic [2:0] S_MEET = 3'd4;  // hi >= lo ?
   localparam logic [2:0] S_ADV  = 3'd5;  // advance X or Y
   localparam logic [2:0] S_FIN  = 3'd6;  // flush final result

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         x_ptr_ff, x_ptr_in;
   logic [CNT_W-1:0]         y_ptr_ff, y_ptr_in;
   logic                     pend_ff, pend_in;
   logic signed [SPAN_W-1:0] lo_ff, lo_in;
   logic signed [SPAN_W-1:0] hi_ff, hi_in;
   logic signed [SPAN_W-1:0] pend_lo_ff, pend_lo_in;
   logic signed [SPAN_W-1:0] pend_hi_ff, pend_hi_in;
   logic signed [SPAN_W-1:0] cmp_a;
   logic signed [SPAN_W-1:0] cmp_b;
   logic                     cmp_lt;

   sli_cmp u_cmp (
      .a_in (cmp_a),
      .b_in (cmp_b),
      .lt   (cmp_lt)
   );

   // operand select for the shared comparator
   always_comb begin
      cmp_a = '0;
      cmp_b = '0;
      case (state_ff)
         S_LO: begin
            cmp_a = x_rd.span_start;
            cmp_b = y_rd.span_start;
         end
         S_HI: begin
            cmp_a = y_rd.span_end;
            cmp_b = x_rd.span_end;
         end
         S_MEET: begin
            cmp_a = hi_ff;
            cmp_b = lo_ff;
         end
         S_ADV: begin
            cmp_a = x_rd.span_end;
            cmp_b = y_rd.span_end;
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      x_ptr_in   = x_ptr_ff;
      y_ptr_in   = y_ptr_ff;
      pend_in    = pend_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      pend_lo_in = pend_lo_ff;
      pend_hi_in = pend_hi_ff;
      emit       = '0;
      done       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_ptr_in = '0;
               y_ptr_in = '0;
               pend_in  = 1'b0;
               if (x_count == '0 || y_count == '0) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_LO;
         end
         S_LO: begin
            lo_in    = cmp_lt ? y_rd.span_start : x_rd.span_start;
            state_in = S_HI;
         end
         S_HI: begin
            hi_in    = cmp_lt ? y_rd.span_end : x_rd.span_end;
            state_in = S_MEET;
         end
         S_MEET: begin
            if (!cmp_lt) begin
               // a new span replaces the held one, which is then not the last
               if (!pend_ff || out_free) begin
                  emit.valid          = pend_ff;
                  emit.has_span       = 1'b1;
                  emit.span_start_res = pend_lo_ff;
                  emit.span_end_res   = pend_hi_ff;
                  pend_in             = 1'b1;
                  pend_lo_in          = lo_ff;
                  pend_hi_in          = hi_ff;
                  state_in            = S_ADV;
               end
            end else begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            if (cmp_lt) begin
               x_ptr_in = x_ptr_ff + 1'b1;
            end else begin
               y_ptr_in = y_ptr_ff + 1'b1;
            end
            if (x_ptr_in == x_count || y_ptr_in == y_count) begin
               state_in = S_FIN;
            end else begin
               state_in = S_READ;
            end
         end
         S_FIN: begin
            if (out_free) begin
               emit.valid          = 1'b1;
               emit.has_span       = pend_ff;
               emit.last           = 1'b1;
               emit.span_start_res = pend_ff ? pend_lo_ff : '0;
               emit.span_end_res   = pend_ff ? pend_hi_ff : '0;
               done                = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         x_ptr_ff <= '0;
         y_ptr_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         x_ptr_ff <= x_ptr_in;
         y_ptr_ff <= y_ptr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      pend_lo_ff <= pend_lo_in;
      pend_hi_ff <= pend_hi_in;
   end

   assign x_ptr = x_ptr_ff;
   assign y_ptr = y_ptr_ff;
   assign busy  = (state_ff != S_IDLE);

endmodule

@@ hw/rtl/sorted_interval_list_intersect.sv @@
// Top level: sorted span list intersect with load handshake and result register.
//
// Two lists of closed signed 64-bit spans, X and Y, are loaded one item per
// cycle while no intersect runs (req_tuser = 0 for X, 1 for Y); a load into
// a full list is dropped and a load gives no result. An intersect item
// (req_tuser = 2) walks both lists with two pointers and returns one item
// per overlapping pair, [max of starts, min of ends], in walk order; the
// final item has rsp_tlast set. If either list is empty or nothing overlaps,
// a single item with rsp_tuser (has_span) low, zero span fields and rsp_tlast
// high is returned. Both lists are empty again afterwards. req_tuser = 3 is
// ignored. An intersect holds req_tready low until its final item is handed
// off; at most x_count + y_count - 1 pairs are visited, and each visited
// pair costs one registered list read plus four passes through the single
// shared 64-bit comparator (max of starts, min of ends, overlap test,
// advance decision); a final state then hands off the last item.
// Output back-pressure stalls the walk only when a new result finds the
// output register still full. No clearing pass after reset: list contents
// are tracked by the fill counts alone.
module sorted_interval_list_intersect #(
   parameter int SPAN_SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] span_start, [127:64] span_end
   input  logic [1:0]   req_tuser,   // [1:0] operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] span_start_res, [127:64] span_end_res
   output logic         rsp_tuser,   // [0] has_span
   output logic         rsp_tlast
);
   import sli_pkg::*;

   localparam int CNT_W = $clog2(SPAN_SLOTS+1);
   localparam int IDX_W = (SPAN_SLOTS > 1) ? $clog2(SPAN_SLOTS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SPAN_SLOTS);

   logic [CNT_W-1:0] x_count_ff, x_count_in;
   logic [CNT_W-1:0] y_count_ff, y_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_has_ff;
   logic             rsp_last_ff;
   logic [127:0]     rsp_data_ff;

   logic             accept;
   logic             load_x;
   logic             load_y;
   logic             walk_start;
   logic             walk_done;
   logic             walk_busy;
   logic             out_free;
   logic [CNT_W-1:0] x_ptr;
   logic [CNT_W-1:0] y_ptr;
   span_type         in_span;
   span_type         x_rd;
   span_type         y_rd;
   emit_type         emit;

   assign req_tready = !walk_busy;
   assign accept     = req_tvalid && req_tready;

   assign in_span = '{span_end: req_tdata[127:64], span_start: req_tdata[63:0]};

   // full lists silently drop further loads
   assign load_x     = accept && (req_tuser == OP_LOAD_X) && (x_count_ff < CNT_MAX);
   assign load_y     = accept && (req_tuser == OP_LOAD_Y) && (y_count_ff < CNT_MAX);
   assign walk_start = accept && (req_tuser == OP_ISECT);

   sli_span_mem #(.DEPTH(SPAN_SLOTS)) u_x_mem (
      .clock   (clock),
      .wr_en   (load_x),
      .wr_addr (x_count_ff[IDX_W-1:0]),
      .wr_data (in_span),
      .rd_addr (x_ptr[IDX_W-1:0]),
      .rd_data (x_rd)
   );

   sli_span_mem #(.DEPTH(SPAN_SLOTS)) u_y_mem (
      .clock   (clock),
      .wr_en   (load_y),
      .wr_addr (y_count_ff[IDX_W-1:0]),
      .wr_data (in_span),
      .rd_addr (y_ptr[IDX_W-1:0]),
      .rd_data (y_rd)
   );

   sli_walk #(.SPAN_SLOTS(SPAN_SLOTS)) u_walk (
      .clock    (clock),
      .reset    (reset),
      .start    (walk_start),
      .x_count  (x_count_ff),
      .y_count  (y_count_ff),
      .x_rd     (x_rd),
      .y_rd     (y_rd),
      .out_free (out_free),
      .x_ptr    (x_ptr),
      .y_ptr    (y_ptr),
      .emit     (emit),
      .done     (walk_done),
      .busy     (walk_busy)
   );

   // fill counts; cleared when the intersect hands off its final item
   always_comb begin
      x_count_in = x_count_ff;
      y_count_in = y_count_ff;
      if (walk_done) begin
         x_count_in = '0;
         y_count_in = '0;
      end else begin
         if (load_x) begin
            x_count_in = x_count_ff + 1'b1;
         end
         if (load_y) begin
            y_count_in = y_count_ff + 1'b1;
         end
      end
   end

   // output register: the walk may write it when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff   <= '0;
         y_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_count_ff   <= x_count_in;
         y_count_ff   <= y_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_data_ff <= {emit.span_end_res, emit.span_start_res};
         rsp_has_ff  <= emit.has_span;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the walk never pushes a result while loads are being taken
   a_emit_only_busy: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> !req_tready)
      else $error("result pushed while block idle");

   // the walk never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("output register overwritten");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (x_count_ff <= CNT_MAX) && (y_count_ff <= CNT_MAX))
      else $error("list count beyond capacity");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      walk_done |=> (x_count_ff == '0) && (y_count_ff == '0))
      else $error("lists not cleared after intersect");

   // an empty result is always the only, hence last, item with zero fields
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && (rsp_tdata == '0)))
      else $error("empty result malformed");
`endif

endmodule
